[src/olfbd_pkg.sv]
// Shared types and constants for the ordered list unit.
package olfbd_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned POS_W    = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_FRONT  = 2'd0,
    MODE_BACK   = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_IN,
    OP_WRITE_TAIL,
    OP_DELETE,
    OP_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  last;
  } cell_cmd_t;

endpackage

[src/olfbd_cell.sv]
// One list slot: holds one element and moves data to and from its neighbors.
module olfbd_cell (
  input  logic                       clk_i,
  input  olfbd_pkg::cell_cmd_t       cmd_i,
  input  logic [olfbd_pkg::IDX_W-1:0]  idx_i,
  input  logic [olfbd_pkg::DATA_W-1:0] left_i,
  input  logic [olfbd_pkg::DATA_W-1:0] right_i,
  input  logic [olfbd_pkg::DATA_W-1:0] head_i,
  output logic [olfbd_pkg::DATA_W-1:0] data_o
);
  import olfbd_pkg::*;

  logic [DATA_W-1:0] data_q, data_d;
  logic [CNT_W-1:0]  idx_ext;

  assign idx_ext = {1'b0, idx_i};

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      OP_HOLD:       data_d = data_q;
      OP_SHIFT_IN:   data_d = left_i;
      OP_WRITE_TAIL: begin
        if (idx_ext == cmd_i.count) data_d = cmd_i.value;
      end
      OP_DELETE: begin
        if (idx_ext >= cmd_i.pos) data_d = right_i;
      end
      OP_ROTATE: begin
        if (idx_ext < cmd_i.last) begin
          data_d = right_i;
        end else if (idx_ext == cmd_i.last) begin
          data_d = head_i;
        end
      end
      default:       data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[src/ordered_list_front_back_indexed_delete_unit.sv]
// Top level: bounded list held in a chain of slots, dumped front to back after each op.
// Latency: an op is applied in its accept cycle; the first result is valid the next cycle.
// Flow: a new op is accepted only in idle; the dump then rotates the slot chain once per
// delivered result and returns to idle after the last result is taken (one result when empty).
// Reset: asynchronous, active low; the list is empty after reset, slot contents are not cleared.
module ordered_list_front_back_indexed_delete_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [31:0] value, [39:32] position
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] element
  output logic        m_axis_tlast_o,   // is_last
  output logic [1:0]  m_axis_tuser_o    // [0] list_empty, [1] insert_dropped
);
  import olfbd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic              drop_q, drop_d;
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic              s_fire, m_fire, full, empty;
  mode_e             mode;
  logic [DATA_W-1:0] in_value;
  logic [POS_W-1:0]  in_pos;

  assign mode     = mode_e'(s_axis_tuser_i);
  assign in_value = s_axis_tdata_i[DATA_W-1:0];
  assign in_pos   = s_axis_tdata_i[DATA_W +: POS_W];
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire   = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    out_cnt_d = out_cnt_q;
    drop_d    = drop_q;
    cmd.op    = OP_HOLD;
    cmd.value = in_value;
    cmd.pos   = in_pos[CNT_W-1:0];
    cmd.count = count_q;
    cmd.last  = count_q - CNT_W'(1);
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          state_d   = ST_DUMP;
          out_cnt_d = '0;
          drop_d    = 1'b0;
          case (mode)
            MODE_FRONT, MODE_BACK: begin
              if (full) begin
                drop_d = 1'b1;
              end else begin
                cmd.op  = (mode == MODE_FRONT) ? OP_SHIFT_IN : OP_WRITE_TAIL;
                count_d = count_q + CNT_W'(1);
              end
            end
            MODE_DELETE: begin
              if (in_pos < POS_W'(count_q)) begin
                cmd.op  = OP_DELETE;
                count_d = count_q - CNT_W'(1);
              end
            end
            default: cmd.op = OP_HOLD;
          endcase
        end
      end
      ST_DUMP: begin
        if (m_fire) begin
          if (!empty) cmd.op = OP_ROTATE;
          out_cnt_d = out_cnt_q + CNT_W'(1);
          if (m_axis_tlast_o) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      out_cnt_q <= '0;
      drop_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      out_cnt_q <= out_cnt_d;
      drop_q    <= drop_d;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = cmd.value;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    olfbd_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (IDX_W'(i)),
      .left_i  (left),
      .right_i (right),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[i])
    );
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_DUMP);
  assign m_axis_tdata_o  = empty ? '0 : cell_data[0];
  assign m_axis_tlast_o  = empty || ((out_cnt_q + CNT_W'(1)) == count_q);
  assign m_axis_tuser_o  = {drop_q, empty};

endmodule

[tb/ordered_list_front_back_indexed_delete_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the ordered list unit: directed table, then random ops.
module ordered_list_front_back_indexed_delete_unit_tb;
  import olfbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DIR_ROWS    = 24;

  typedef struct packed {
    logic [31:0] element;
    logic        is_last;
    logic        is_empty;
    logic        dropped;
  } beat_t;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] value;
    logic [7:0]  pos;
    logic [7:0]  reps;
    logic        fixed;
    beat_t       fixed_beat;
  } dir_row_t;

  localparam dir_row_t DIR_PLAN [DIR_ROWS] = '{
    // empty list cases
    '{MODE_DELETE, 32'h0000_0000, 8'd0,   8'd1,  1'b1, '{32'h0, 1'b1, 1'b1, 1'b0}},
    '{MODE_NONE,   32'hFFFF_FFFF, 8'd0,   8'd1,  1'b1, '{32'h0, 1'b1, 1'b1, 1'b0}},
    '{MODE_DELETE, 32'h0000_0000, 8'd255, 8'd1,  1'b1, '{32'h0, 1'b1, 1'b1, 1'b0}},
    // one to three elements, value extremes
    '{MODE_FRONT,  32'h8000_0000, 8'd0,   8'd1,  1'b1, '{32'h8000_0000, 1'b1, 1'b0, 1'b0}},
    '{MODE_DELETE, 32'h0000_0000, 8'd1,   8'd1,  1'b1, '{32'h8000_0000, 1'b1, 1'b0, 1'b0}},
    '{MODE_DELETE, 32'h0000_0000, 8'd0,   8'd1,  1'b1, '{32'h0, 1'b1, 1'b1, 1'b0}},
    '{MODE_BACK,   32'h7FFF_FFFF, 8'd0,   8'd1,  1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0}},
    '{MODE_FRONT,  32'hFFFF_FFFF, 8'd0,   8'd1,  1'b0, '0},
    '{MODE_BACK,   32'h0000_0000, 8'd0,   8'd1,  1'b0, '0},
    '{MODE_DELETE, 32'h0000_0000, 8'd1,   8'd1,  1'b0, '0},
    '{MODE_DELETE, 32'h0000_0000, 8'd1,   8'd1,  1'b0, '0},
    '{MODE_NONE,   32'h0000_0000, 8'd255, 8'd1,  1'b0, '0},
    // fill up to capacity
    '{MODE_BACK,   32'h0000_1000, 8'd0,   8'd30, 1'b0, '0},
    '{MODE_FRONT,  32'hA5A5_0000, 8'd0,   8'd31, 1'b0, '0},
    '{MODE_BACK,   32'h5555_5555, 8'd0,   8'd1,  1'b0, '0},
    '{MODE_FRONT,  32'hAAAA_AAAA, 8'd0,   8'd1,  1'b0, '0},
    // full list inserts are dropped, then mixed ops at the list edges
    '{MODE_BACK,   32'h0000_1234, 8'd0,   8'd1,  1'b0, '0},
    '{MODE_FRONT,  32'h0000_5678, 8'd0,   8'd1,  1'b0, '0},
    '{MODE_DELETE, 32'h0000_0000, 8'd63,  8'd1,  1'b0, '0},
    '{MODE_DELETE, 32'h0000_0000, 8'd64,  8'd1,  1'b0, '0},
    '{MODE_BACK,   32'h0000_0000, 8'd0,   8'd1,  1'b0, '0},
    '{MODE_DELETE, 32'h0000_0000, 8'd0,   8'd1,  1'b0, '0},
    '{MODE_DELETE, 32'h0000_0000, 8'd255, 8'd1,  1'b0, '0},
    '{MODE_NONE,   32'h0000_0000, 8'd0,   8'd1,  1'b0, '0}
  };

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i  = '0;  // [31:0] value, [39:32] position
  logic [1:0]  s_axis_tuser_i  = '0;  // [1:0] mode
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;        // [31:0] element
  logic        m_axis_tlast_o;
  logic [1:0]  m_axis_tuser_o;        // [0] list_empty, [1] insert_dropped

  ordered_list_front_back_indexed_delete_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // shadow copy of the list
  logic [31:0] shadow_list [CAPACITY];
  int unsigned shadow_len = 0;
  beat_t       dump_q [$];

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_ask     = 0;
  int unsigned hold_done    = 0;
  int unsigned hold_left    = 0;
  int unsigned mism_cnt     = 0;
  int unsigned cycle_cnt    = 0;

  function automatic logic list_update(mode_e m, logic [31:0] v, logic [7:0] p);
    int unsigned i;
    logic        drop;
    drop = 1'b0;
    case (m)
      MODE_FRONT, MODE_BACK: begin
        if (shadow_len >= CAPACITY) begin
          drop = 1'b1;
        end else if (m == MODE_FRONT) begin
          for (i = shadow_len; i > 0; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[0] = v;
          shadow_len++;
        end else begin
          shadow_list[shadow_len] = v;
          shadow_len++;
        end
      end
      MODE_DELETE: begin
        if (p < shadow_len) begin
          for (i = p; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      default: ;
    endcase
    return drop;
  endfunction

  function automatic void push_dump(logic drop);
    int unsigned i;
    if (shadow_len == 0) begin
      dump_q.push_back('{32'h0, 1'b1, 1'b1, drop});
    end else begin
      for (i = 0; i < shadow_len; i++)
        dump_q.push_back('{shadow_list[i], (i + 1 == shadow_len), 1'b0, drop});
    end
  endfunction

  task automatic send_item(mode_e m, logic [31:0] v, logic [7:0] p, logic fixed,
                           beat_t fixed_beat);
    logic drop;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {p, v};
    s_axis_tuser_i  <= m;
    do @(posedge clk_i); while (!s_axis_tready_o);
    drop = list_update(m, v, p);
    if (fixed) dump_q.push_back(fixed_beat);
    else push_dump(drop);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 40'({$urandom, $urandom});
      @(negedge clk_i);
    end
  endtask

  // receiver: random stalls plus long hold-off on request
  always @(negedge clk_i) begin
    if (hold_ask != hold_done) begin
      hold_done       <= hold_ask;
      hold_left       <= HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    beat_t want;
    logic  bad;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (dump_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10)
          $display("unexpected transaction: element %h last %b user %b",
                   m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
      end else begin
        want = dump_q.pop_front();
        bad  = (want.is_last != m_axis_tlast_o) || (want.is_empty != m_axis_tuser_o[0]) ||
               (want.dropped != m_axis_tuser_o[1]) ||
               (!want.is_empty && want.element != m_axis_tdata_o);
        if (bad) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("mismatch: exp element %h last %b empty %b dropped %b, got %h %b %b %b",
                     want.element, want.is_last, want.is_empty, want.dropped,
                     m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o[0], m_axis_tuser_o[1]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("ordered_list_front_back_indexed_delete_unit verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned row;
    int unsigned k;
    int unsigned phase;
    int unsigned len_goal;
    int unsigned roll;
    mode_e       m;
    logic [31:0] v;
    logic [7:0]  p;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (row = 0; row < DIR_ROWS; row++)
      for (k = 0; k < DIR_PLAN[row].reps; k++)
        send_item(DIR_PLAN[row].mode, DIR_PLAN[row].value + k, DIR_PLAN[row].pos,
                  DIR_PLAN[row].fixed, DIR_PLAN[row].fixed_beat);

    len_goal = 0;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
        default: begin tx_idle_pct = 28; rx_stall_pct = 28; end
      endcase
      if (phase == 1)
        while (dump_q.size() != 0) @(negedge clk_i);
      if (phase == 2) begin
        @(posedge clk_i);
        hold_ask++;
        @(negedge clk_i);
      end
      for (k = 0; k < 20; k++) begin
        if (k % 10 == 0) begin
          case ($urandom_range(3))
            0: len_goal = 0;
            1: len_goal = CAPACITY;
            2: len_goal = 8;
            default: len_goal = $urandom_range(CAPACITY);
          endcase
        end
        roll = $urandom_range(99);
        v = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                     : $urandom;
        p = 8'($urandom);
        if (roll < 4) begin
          m = MODE_NONE;
        end else if ((shadow_len < len_goal) == (roll < 89)) begin
          m = $urandom_range(1) ? MODE_FRONT : MODE_BACK;
        end else begin
          m = MODE_DELETE;
          if (shadow_len != 0 && $urandom_range(9) != 0)
            p = 8'($urandom_range(shadow_len - 1));
          else p = 8'(shadow_len + $urandom_range(255 - shadow_len));
        end
        send_item(m, v, p, 1'b0, '0);
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (dump_q.size() != 0) @(posedge clk_i);
    repeat (4 * CAPACITY) @(posedge clk_i);
    if (mism_cnt == 0 && dump_q.size() == 0) begin
      $display("ordered_list_front_back_indexed_delete_unit verification clean");
    end else begin
      $display("ordered_list_front_back_indexed_delete_unit verification failed");
    end
    $finish;
  end

endmodule
